FILE: rtl/pair_key_hash_table_linear_probe_top_macros.svh
// Assertion macros used by the hash table RTL.
`ifndef PAIR_KEY_HASH_TABLE_LINEAR_PROBE_TOP_MACROS_SVH
`define PAIR_KEY_HASH_TABLE_LINEAR_PROBE_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define PKHTLP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define PKHTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pkhtlp_pkg.sv
// Shared types and constants of the pair-keyed hash table.
package pkhtlp_pkg;

   localparam int KEY_W      = 31;
   localparam int VAL_W      = 31;
   localparam int CNT_W      = 11;
   localparam int HASH_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] MAX_LOAD_RESET = 11'd768;

   // command codes
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // register index (address bit 2)
   localparam logic CSR_IDX_MAX_LOAD = 1'b0;

   // one slot of the table memory
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key_second;
      logic [KEY_W-1:0] key_first;
      logic [VAL_W-1:0] value;
   } slot_type;

endpackage

FILE: rtl/pkhtlp_req_if.sv
// Request channel: command word with key pair and value.
interface pkhtlp_req_if import pkhtlp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             command;
   logic [KEY_W-1:0] key_first;
   logic [KEY_W-1:0] key_second;
   logic [VAL_W-1:0] value;

   modport source (output valid, command, key_first, key_second, value, input ready);
   modport sink   (input valid, command, key_first, key_second, value, output ready);
endinterface

FILE: rtl/pkhtlp_rsp_if.sv
// Response channel: success flag and looked-up value.
interface pkhtlp_rsp_if import pkhtlp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             success;
   logic [VAL_W-1:0] value_out;

   modport source (output valid, success, value_out, input ready);
   modport sink   (input valid, success, value_out, output ready);
endinterface

FILE: rtl/pkhtlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pkhtlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pair_key_hash_table_linear_probe_top.sv
// Top level of the pair-keyed open-addressing hash table with linear probing.
//
//   channel   direction  handshake             word
//   req_chan  in         valid/ready           command, key_first, key_second, value
//   rsp_chan  out        valid/ready           success, value_out
//   csr_*     in/out     APB, pready tied high max_load_entries at address 0
//
// Steps per word when TABLE_SIZE is a power of two: accept, read, compare,
// result, plus a read and a compare for each extra probe slot; when it is not,
// a reciprocal multiply step and a fold step form the home slot first. The table
// RAM read port sets the probe rate: one read issue plus one compare per slot.
// After reset a clearing pass writes every slot empty, with req_chan.ready low;
// CSR writes are taken throughout.
// One word is in flight at a time; a finished response waits in the output
// register while the next request is accepted and hashed.
`include "pair_key_hash_table_linear_probe_top_macros.svh"

module pair_key_hash_table_linear_probe_top import pkhtlp_pkg::*; #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   pkhtlp_req_if.sink            req_chan,
   pkhtlp_rsp_if.source          rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
   localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(TABLE_SIZE - 1);
   // exact quotient for any 32-bit dividend: ceil(2^(32+l) / size) and shift 32+l
   localparam int RECIP_SHIFT = HASH_W + ADDR_W;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << RECIP_SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [HASH_W:0] RECIP = RECIP_WIDE[HASH_W:0];
   localparam logic [ADDR_W-1:0] TS_LOW = ADDR_W'(TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_REDUCE,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [CNT_W-1:0]    probes_ff;
   logic [CNT_W-1:0]    entry_count_ff;
   logic [CNT_W-1:0]    max_load_ff;
   logic [HASH_W-1:0]   mixed_ff;
   logic [ADDR_W-1:0]   quot_ff;
   logic                cmd_ff;
   logic [KEY_W-1:0]    key_first_ff;
   logic [KEY_W-1:0]    key_second_ff;
   logic [VAL_W-1:0]    value_ff;
   logic                res_success_ff;
   logic [VAL_W-1:0]    res_value_ff;
   logic                rsp_valid_ff;
   logic                rsp_success_ff;
   logic [VAL_W-1:0]    rsp_value_ff;

   // home slot mixing: (a + (a << 16)) ^ b, 32-bit wrap
   logic [HASH_W-1:0]   mix_sum;
   logic [HASH_W-1:0]   mixed;
   // remainder by reciprocal: quotient, then low bits of x - q * size
   logic [2*HASH_W:0]   recip_prod;
   logic [ADDR_W-1:0]   hash_quot;
   logic [ADDR_W-1:0]   hash_fold;
   logic [ADDR_W-1:0]   hash_rem;
   logic [ADDR_W-1:0]   pos_next;

   // table memory
   slot_type            rd_slot;
   slot_type            wr_slot;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [$bits(slot_type)-1:0] ram_rd_data;

   // probe decision
   logic                at_limit;
   logic                key_match;
   logic                hit;
   logic                probe_continue;
   logic                insert_new;
   logic                eval_success;
   logic [VAL_W-1:0]    eval_value;
   logic                csr_wr;

   assign mix_sum = {1'b0, req_chan.key_first} + {req_chan.key_first[15:0], 16'h0000};
   assign mixed   = mix_sum ^ {1'b0, req_chan.key_second};

   // remainder is below the size, so ADDR_W bits of the difference are exact
   assign recip_prod = (2*HASH_W+1)'(mixed_ff) * (2*HASH_W+1)'(RECIP);
   assign hash_quot  = ADDR_W'(recip_prod >> RECIP_SHIFT);
   assign hash_fold  = quot_ff * TS_LOW;
   assign hash_rem   = mixed_ff[ADDR_W-1:0] - hash_fold;

   assign pos_next = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;

   assign rd_slot   = slot_type'(ram_rd_data);
   assign at_limit  = (probes_ff >= max_load_ff);
   assign key_match = ({rd_slot.key_second, rd_slot.key_first} ==
                       {key_second_ff, key_first_ff});
   assign hit            = rd_slot.valid && !at_limit && key_match;
   assign probe_continue = rd_slot.valid && !at_limit && !key_match;
   // new entry only where the probe stopped on an empty slot
   assign insert_new = (cmd_ff == CMD_INSERT) && !rd_slot.valid &&
                       (entry_count_ff < max_load_ff);
   assign eval_success = (cmd_ff == CMD_LOOKUP) ? hit : (hit || insert_new);
   assign eval_value   = ((cmd_ff == CMD_LOOKUP) && hit) ? rd_slot.value : '0;

   always_comb begin
      wr_slot            = '0;
      ram_wr_en          = 1'b0;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == ST_EVAL && cmd_ff == CMD_INSERT && (hit || insert_new)) begin
         ram_wr_en          = 1'b1;
         wr_slot.valid      = 1'b1;
         wr_slot.key_second = key_second_ff;
         wr_slot.key_first  = key_first_ff;
         wr_slot.value      = value_ff;
      end
   end

   assign ram_rd_en = (state_ff == ST_READ);

   pkhtlp_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (TABLE_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (wr_slot),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // CSR port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_LOAD)
                       ? {{(CSR_DATA_W - CNT_W){1'b0}}, max_load_ff} : '0;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.success   = rsp_success_ff;
   assign rsp_chan.value_out = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         pos_ff         <= '0;
         entry_count_ff <= '0;
         max_load_ff    <= MAX_LOAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr && csr_paddr[2] == CSR_IDX_MAX_LOAD) begin
            max_load_ff <= csr_pwdata[CNT_W-1:0];
         end
         // output register loads from the finish step, else drains on ready
         if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               pos_ff <= pos_next;
               if (pos_ff == POS_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff        <= req_chan.command;
                  key_first_ff  <= req_chan.key_first;
                  key_second_ff <= req_chan.key_second;
                  value_ff      <= req_chan.value;
                  probes_ff     <= '0;
                  mixed_ff      <= mixed;
                  if (IS_POW2) begin
                     pos_ff   <= mixed[ADDR_W-1:0];
                     state_ff <= ST_READ;
                  end else begin
                     state_ff <= ST_HASH;
                  end
               end
            end
            ST_HASH: begin
               quot_ff  <= hash_quot;
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               pos_ff   <= hash_rem;
               state_ff <= ST_READ;
            end
            ST_READ: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (probe_continue) begin
                  probes_ff <= probes_ff + 1'b1;
                  pos_ff    <= pos_next;
                  state_ff  <= ST_READ;
               end else begin
                  res_success_ff <= eval_success;
                  res_value_ff   <= eval_value;
                  if (insert_new) begin
                     entry_count_ff <= entry_count_ff + 1'b1;
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_success_ff <= res_success_ff;
                  rsp_value_ff   <= res_value_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a word in flight blocks the next one
   `PKHTLP_ASSERT_NEXT(ast_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready, "request accepted while busy")
   // entry count moves only on the compare step
   `PKHTLP_ASSERT_NEXT(ast_count_stable, state_ff != ST_EVAL, $stable(entry_count_ff), "entry count changed outside compare")
   // every table write on the compare step reports success
   `PKHTLP_ASSERT_NEXT(ast_write_success, state_ff == ST_EVAL && ram_wr_en, res_success_ff, "slot written without success")

endmodule

FILE: tb/pkhtlp_table_checker.sv
// Checker for the pair-keyed hash table: shadow table, expected result words, compare.
module pkhtlp_table_checker import pkhtlp_pkg::*; #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   pkhtlp_req_if                 req_mon,
   pkhtlp_rsp_if                 rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    pending_words
);

   typedef struct packed {
      logic             success;
      logic [VAL_W-1:0] value_out;
   } result_type;

   // shadow of the table; keys held as {key_second, key_first}
   logic               slot_used  [TABLE_SIZE];
   logic [2*KEY_W-1:0] slot_key   [TABLE_SIZE];
   logic [VAL_W-1:0]   slot_value [TABLE_SIZE];
   logic [CNT_W-1:0]   entry_count;
   logic [CNT_W-1:0]   load_limit;
   result_type         predicted_words[$];

   // walks the probe chain of one request word and applies it to the shadow
   function automatic result_type probe_table(input logic             cmd,
                                              input logic [KEY_W-1:0] first,
                                              input logic [KEY_W-1:0] second,
                                              input logic [VAL_W-1:0] val);
      logic [HASH_W-1:0]  wide_first;
      logic [HASH_W-1:0]  mix;
      logic [2*KEY_W-1:0] key;
      int unsigned        pos;
      int unsigned        probes;
      logic               hit;
      logic               blocked;
      result_type         res;
      wide_first = HASH_W'(first);
      mix        = (wide_first + (wide_first << 16)) ^ HASH_W'(second);
      pos        = int'(mix % TABLE_SIZE);
      key        = {second, first};
      probes     = 0;
      hit        = 1'b0;
      blocked    = 1'b0;
      res        = '0;
      while (slot_used[pos]) begin
         if (probes >= load_limit) begin
            blocked = 1'b1;
            break;
         end
         if (slot_key[pos] == key) begin
            hit = 1'b1;
            break;
         end
         probes++;
         pos = (pos + 1) % TABLE_SIZE;
      end
      if (cmd == CMD_LOOKUP) begin
         if (hit) begin
            res.success   = 1'b1;
            res.value_out = slot_value[pos];
         end
      end else if (hit) begin
         slot_value[pos] = val;
         res.success     = 1'b1;
      end else if (!blocked && entry_count < load_limit) begin
         slot_used[pos]  = 1'b1;
         slot_key[pos]   = key;
         slot_value[pos] = val;
         entry_count     = entry_count + 1'b1;
         res.success     = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 1'b0;
         entry_count = '0;
         load_limit  = MAX_LOAD_RESET;
         predicted_words.delete();
      end else begin
         // result first: a word accepted now cannot answer a request of this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.success   = rsp_mon.success;
            got.value_out = rsp_mon.value_out;
            if (predicted_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got success=%0b value_out=%h",
                        $time, got.success, got.value_out);
               fail_count++;
            end else begin
               want = predicted_words.pop_front();
               if (got.success !== want.success) begin
                  $display("%0t: success mismatch, expected %0b, got %0b",
                           $time, want.success, got.success);
                  fail_count++;
               end
               if (got.value_out !== want.value_out) begin
                  $display("%0t: value_out mismatch, expected %h, got %h",
                           $time, want.value_out, got.value_out);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_words.push_back(probe_table(req_mon.command, req_mon.key_first,
                                                  req_mon.key_second, req_mon.value));
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_MAX_LOAD) begin
            if (csr_pwrite) begin
               load_limit = csr_pwdata[CNT_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(load_limit)) begin
               $display("%0t: max_load_entries readback mismatch, expected %h, got %h",
                        $time, CSR_DATA_W'(load_limit), csr_prdata);
               fail_count++;
            end
         end
      end
      pending_words = predicted_words.size();
   end

endmodule

FILE: tb/pair_key_hash_table_linear_probe_top_tb.sv
// Stimulus and verdict for the pair-keyed hash table; checking lives in the checker.
module pair_key_hash_table_linear_probe_top_tb import pkhtlp_pkg::*; ();

   localparam int TABLE_SIZE       = 1024;
   localparam int SLOT_W           = $clog2(TABLE_SIZE);
   localparam int CLOCK_PERIOD     = 12;
   // far above the slowest legal run: clearing pass, deep probe chains,
   // the long receiver hold and every sender gap, several times over
   localparam int RUN_LIMIT_CYCLES = 2_500_000;
   localparam int PHASE_WORDS      = 60;
   localparam int LONG_HOLD_CYCLES = 300;

   localparam logic [CSR_ADDR_W-1:0] LOAD_LIMIT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MAX_LOAD);
   localparam logic [VAL_W-1:0]      VAL_ALL_ONES    = '1;

   typedef struct packed {
      logic [KEY_W-1:0] second;
      logic [KEY_W-1:0] first;
   } key_pair_type;

   // how the receiver behaves for a stretch of cycles
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PATTERN
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    words_pending;

   key_pair_type inserted_keys[$]; // every key ever offered for insert
   int           hot_slots[6];     // home slots that keys pile onto to build long chains
   int unsigned  burst_left;       // words left before the sender takes a gap
   int unsigned  rsp_hold_cycles;  // set by the stimulus, consumed by the receiver

   pkhtlp_req_if req_chan ();
   pkhtlp_rsp_if rsp_chan ();

   pair_key_hash_table_linear_probe_top #(.TABLE_SIZE(TABLE_SIZE)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pkhtlp_table_checker #(.TABLE_SIZE(TABLE_SIZE)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_words (words_pending)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Random key whose home slot is the one asked for. Below bit 16 the hash is
   // plain key_first ^ key_second, so fixing the low bits of key_second pins the
   // slot while every other bit stays random.
   function automatic key_pair_type key_at_slot(input int unsigned slot);
      key_pair_type k;
      k.first  = KEY_W'($urandom);
      k.second = KEY_W'($urandom);
      k.second[SLOT_W-1:0] = k.first[SLOT_W-1:0] ^ SLOT_W'(slot);
      return k;
   endfunction

   // mostly random, with both extremes turning up now and then
   function automatic logic [VAL_W-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return VAL_ALL_ONES;
      return VAL_W'($urandom);
   endfunction

   // One APB transfer: setup cycle, then access cycle until pready.
   // The checker follows writes and checks read data itself.
   task automatic csr_access(input logic is_write, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= LOAD_LIMIT_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Sender stops and waits until every expected result word is back.
   // Every request yields a word, so an empty queue means the block is idle.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   // register writes only ever land on an idle block
   task automatic set_load_limit(input logic [CNT_W-1:0] limit);
      drain_results();
      csr_access(1'b1, CSR_DATA_W'(limit));
      csr_access(1'b0, '0);
   endtask

   // Offer one request word and hold it until taken, then pace the next one:
   // bursts of random length, separated by idle gaps of random length.
   task automatic send_word(input logic cmd, input key_pair_type k,
                            input logic [VAL_W-1:0] val);
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.key_first  <= k.first;
      req_chan.key_second <= k.second;
      req_chan.value      <= val;
      do @(posedge clock); while (!req_chan.ready);
      if (cmd == CMD_INSERT) inserted_keys.push_back(k);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         repeat ($urandom_range(1, 8)) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // One random request. Just under half uses keys offered for insert before,
   // the rest fresh keys and near misses that share a home slot with such a key.
   task automatic random_word();
      int unsigned  pick;
      key_pair_type k;
      pick = $urandom_range(0, 99);
      if (inserted_keys.size() == 0 || pick < 35) begin
         // new key, most of them piled onto a few hot slots
         k = ($urandom_range(0, 9) < 6) ? key_at_slot(hot_slots[$urandom_range(0, 5)])
                                        : key_at_slot($urandom_range(0, TABLE_SIZE - 1));
         send_word(CMD_INSERT, k, random_value());
      end else if (pick < 50) begin
         // update in place
         k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         send_word(CMD_INSERT, k, random_value());
      end else if (pick < 80) begin
         k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         send_word(CMD_LOOKUP, k, random_value());
      end else if (pick < 93) begin
         // most likely a miss, often at the end of a long chain
         k = ($urandom_range(0, 1) == 0) ? key_at_slot(hot_slots[$urandom_range(0, 5)])
                                         : key_at_slot($urandom_range(0, TABLE_SIZE - 1));
         send_word(CMD_LOOKUP, k, random_value());
      end else begin
         // near miss: one high bit of key_second flipped, same home slot
         k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         k.second[$urandom_range(SLOT_W, KEY_W - 1)] ^= 1'b1;
         send_word($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, k, random_value());
      end
   endtask

   // Receiver: ready changes at the falling edge. Each stall mode is drawn at random,
   // as is how long it lasts; a hold asked for by the stimulus is counted out here.
   initial begin
      int unsigned    hold_left;
      int unsigned    mode_left;
      stall_mode_type mode;
      logic [7:0]     pattern;
      hold_left      = 0;
      mode_left      = 0;
      mode           = STALL_NONE;
      pattern        = '0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && rsp_hold_cycles != 0) begin
            hold_left       = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
            pattern   = 8'($urandom);
         end
         mode_left--;
         pattern = {pattern[6:0], pattern[7]};
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:    rsp_chan.ready <= 1'b1;
               STALL_LIGHT:   rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY:   rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               STALL_PATTERN: rsp_chan.ready <= pattern[0];
               default:       rsp_chan.ready <= 1'b1;
            endcase
         end
      end
   end

   // Main stimulus: reset, directed words over several register settings,
   // then random phases, then the verdict.
   initial begin
      key_pair_type zero_key;
      key_pair_type ones_key;
      key_pair_type probe_key;
      key_pair_type wrap_keys[4];
      int unsigned  phase_limits[8];

      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_LOOKUP;
      req_chan.key_first  = '0;
      req_chan.key_second = '0;
      req_chan.value      = '0;
      burst_left          = 0;
      rsp_hold_cycles     = 0;
      hot_slots           = '{0, 1, 2, TABLE_SIZE - 2, TABLE_SIZE - 1, TABLE_SIZE / 2};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset value of the register, read back while the table clears
      csr_access(1'b0, '0);

      // --- directed words at the reset limit ---
      zero_key = '0;
      ones_key = '1;
      send_word(CMD_LOOKUP, zero_key, VAL_ALL_ONES);  // empty table: miss, value ignored
      send_word(CMD_INSERT, zero_key, '0);
      // all-ones key hashes to slot 0 as well, so it lands one along
      send_word(CMD_INSERT, ones_key, VAL_ALL_ONES);
      send_word(CMD_LOOKUP, ones_key, '0);
      send_word(CMD_LOOKUP, zero_key, VAL_ALL_ONES);
      send_word(CMD_INSERT, zero_key, VAL_W'(32'h2AAA_AAAA)); // update in place
      send_word(CMD_LOOKUP, zero_key, '0);
      // chain from the last slot wrapping round past the two at the start
      for (int i = 0; i < 4; i++) begin
         wrap_keys[i] = key_at_slot(TABLE_SIZE - 1);
         send_word(CMD_INSERT, wrap_keys[i], VAL_W'(32'h5555_5555) ^ VAL_W'(i));
      end
      send_word(CMD_LOOKUP, wrap_keys[3], '0);                      // deep hit
      send_word(CMD_LOOKUP, key_at_slot(TABLE_SIZE - 1), random_value()); // miss at gap

      // register zero: every occupied slot stops the probe, nothing is added
      set_load_limit(CNT_W'(0));
      send_word(CMD_LOOKUP, zero_key, '0);
      send_word(CMD_INSERT, key_at_slot(TABLE_SIZE / 2 - 12), random_value());
      send_word(CMD_INSERT, zero_key, random_value());

      // probe limit of two: deep chain blocked, shallow hit still found
      set_load_limit(CNT_W'(2));
      send_word(CMD_LOOKUP, wrap_keys[3], '0);
      send_word(CMD_INSERT, key_at_slot(TABLE_SIZE - 1), random_value());
      send_word(CMD_LOOKUP, ones_key, '0);

      // entry limit: six stored, room for one more, updates still allowed
      set_load_limit(CNT_W'(7));
      send_word(CMD_INSERT, key_at_slot(600), random_value());
      probe_key = key_at_slot(601);
      send_word(CMD_INSERT, probe_key, random_value());    // table at the limit
      send_word(CMD_INSERT, ones_key, random_value());

      // top of the register range
      set_load_limit('1);
      send_word(CMD_INSERT, probe_key, VAL_ALL_ONES);
      send_word(CMD_LOOKUP, probe_key, '0);

      // --- random phases, each under its own limit ---
      phase_limits    = '{16, 3, 0, 1, TABLE_SIZE, (1 << CNT_W) - 1, 768, 0};
      phase_limits[7] = $urandom_range(1, TABLE_SIZE);
      for (int p = 0; p < 8; p++) begin
         set_load_limit(CNT_W'(phase_limits[p]));
         // one long hold-off: the block fills and stalls its input meanwhile
         if (phase_limits[p] == TABLE_SIZE) rsp_hold_cycles = LONG_HOLD_CYCLES;
         repeat (PHASE_WORDS) random_word();
      end

      drain_results();
      repeat (100) @(negedge clock);

      if (fail_count == 0 && words_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("simulation failed");
      $finish;
   end

endmodule
